/* design/sbsvf_pkg.sv */
// Package for the stereo equalizer band: beat types, register indexes,
// controller commands and the per-form command programs.
// No dependencies.
`timescale 1ns / 1ps

package sbsvf_pkg;

  localparam int SAMPLE_BITS = 24;
  localparam int COEF_W      = 32;
  localparam int LEAK_W      = 15;
  localparam int THR_W       = 16;
  localparam int LEAK_FRAC   = 15;
  localparam int SPLIT       = 28;
  localparam int TERM_W      = 62;
  localparam int ACC_W       = 64;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 32;
  localparam int STEP_W      = 5;

  localparam logic [CFG_IDX_W-1:0] REG_FORM  = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_COEF0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COEF1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_COEF2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_COEF3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_COEF4 = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_LEAK  = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_THR   = 3'd7;

  localparam logic [STEP_W-1:0] TAIL_COMMIT = 5'd7;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_sample;
    logic signed [SAMPLE_BITS-1:0] right_sample;
  } in_beat_t;

  typedef struct packed {
    logic signed [SAMPLE_BITS-1:0] left_out;
    logic signed [SAMPLE_BITS-1:0] right_out;
  } out_beat_t;

  typedef enum logic [2:0] {
    CMD_LOAD, CMD_ADD, CMD_MAC, CMD_STORE, CMD_FLUSH, CMD_COMMIT, CMD_END
  } cmd_kind_t;

  typedef enum logic [2:0] {
    OPD_ZERO, OPD_IN, OPD_V1, OPD_V2, OPD_NA, OPD_NB, OPD_NC
  } opnd_t;

  typedef enum logic [2:0] {
    CS_C0, CS_C1, CS_C2, CS_C3, CS_C4, CS_LEAK
  } csel_t;

  typedef enum logic [1:0] {
    DST_NA, DST_NB, DST_NC, DST_OUT
  } dst_t;

  typedef struct packed {
    cmd_kind_t kind;
    logic      neg;
    logic      dbl;
    opnd_t     opnd;
    csel_t     csel;
    dst_t      dst;
  } cmd_t;

  typedef enum logic [2:0] {
    DP_IDLE, DP_ACCEPT, DP_EXEC, DP_MHI, DP_MSUM, DP_MACC, DP_OUTLOAD
  } dp_op_t;

  typedef struct packed {
    dp_op_t op;
    logic   ch;
    cmd_t   cmd;
  } ctrl_t;

  typedef struct packed {
    logic [1:0] form;
    logic       zero;
    logic       out_busy;
  } stat_t;

  typedef enum logic [2:0] {
    S_IDLE, S_EXEC, S_MHI, S_MSUM, S_MACC, S_OUT
  } state_t;

  function automatic cmd_t mk(cmd_kind_t kind, logic neg, logic dbl, opnd_t opnd,
                              csel_t csel, dst_t dst);
    cmd_t c;
    c.kind = kind;
    c.neg  = neg;
    c.dbl  = dbl;
    c.opnd = opnd;
    c.csel = csel;
    c.dst  = dst;
    return c;
  endfunction

  function automatic cmd_t prog_main(logic [1:0] form, logic [STEP_W-1:0] step);
    cmd_t c;
    c = mk(CMD_END, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
    if (form[1]) begin
      case (step)
        5'd0:  c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_IN,   CS_C0, DST_NA);
        5'd1:  c = mk(CMD_ADD,   1'b1, 1'b0, OPD_V2,   CS_C0, DST_NA);
        5'd2:  c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NC);
        5'd3:  c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
        5'd4:  c = mk(CMD_MAC,   1'b0, 1'b0, OPD_V1,   CS_C0, DST_NA);
        5'd5:  c = mk(CMD_MAC,   1'b0, 1'b0, OPD_NC,   CS_C1, DST_NA);
        5'd6:  c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
        5'd7:  c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_V2,   CS_C0, DST_NA);
        5'd8:  c = mk(CMD_MAC,   1'b0, 1'b0, OPD_V1,   CS_C1, DST_NA);
        5'd9:  c = mk(CMD_MAC,   1'b0, 1'b0, OPD_NC,   CS_C2, DST_NA);
        5'd10: c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NB);
        5'd11: c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_IN,   CS_C0, DST_NA);
        5'd12: c = mk(CMD_MAC,   1'b0, 1'b0, OPD_NA,   CS_C3, DST_NA);
        5'd13: c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_OUT);
        5'd14: c = mk(CMD_LOAD,  1'b0, 1'b1, OPD_NA,   CS_C0, DST_NA);
        5'd15: c = mk(CMD_ADD,   1'b1, 1'b0, OPD_V1,   CS_C0, DST_NA);
        5'd16: c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
        5'd17: c = mk(CMD_LOAD,  1'b0, 1'b1, OPD_NB,   CS_C0, DST_NA);
        5'd18: c = mk(CMD_ADD,   1'b1, 1'b0, OPD_V2,   CS_C0, DST_NA);
        5'd19: c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NB);
        default: c = mk(CMD_END, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
      endcase
    end else if (form[0]) begin
      case (step)
        5'd0:  c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
        5'd1:  c = mk(CMD_MAC,   1'b0, 1'b0, OPD_IN,   CS_C0, DST_NA);
        5'd2:  c = mk(CMD_ADD,   1'b0, 1'b0, OPD_V1,   CS_C0, DST_NA);
        5'd3:  c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NC);
        5'd4:  c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_NC,   CS_C0, DST_NA);
        5'd5:  c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_OUT);
        5'd6:  c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_V2,   CS_C0, DST_NA);
        5'd7:  c = mk(CMD_MAC,   1'b0, 1'b0, OPD_IN,   CS_C1, DST_NA);
        5'd8:  c = mk(CMD_MAC,   1'b1, 1'b0, OPD_NC,   CS_C3, DST_NA);
        5'd9:  c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
        5'd10: c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
        5'd11: c = mk(CMD_MAC,   1'b0, 1'b0, OPD_IN,   CS_C2, DST_NA);
        5'd12: c = mk(CMD_MAC,   1'b1, 1'b0, OPD_NC,   CS_C4, DST_NA);
        5'd13: c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NB);
        default: c = mk(CMD_END, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
      endcase
    end else begin
      case (step)
        5'd0:  c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_IN,   CS_C0, DST_NA);
        5'd1:  c = mk(CMD_MAC,   1'b1, 1'b0, OPD_V1,   CS_C3, DST_NA);
        5'd2:  c = mk(CMD_MAC,   1'b1, 1'b0, OPD_V2,   CS_C4, DST_NA);
        5'd3:  c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NC);
        5'd4:  c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
        5'd5:  c = mk(CMD_MAC,   1'b0, 1'b0, OPD_NC,   CS_C0, DST_NA);
        5'd6:  c = mk(CMD_MAC,   1'b0, 1'b0, OPD_V1,   CS_C1, DST_NA);
        5'd7:  c = mk(CMD_MAC,   1'b0, 1'b0, OPD_V2,   CS_C2, DST_NA);
        5'd8:  c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_OUT);
        5'd9:  c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_NC,   CS_C0, DST_NA);
        5'd10: c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
        5'd11: c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_V1,   CS_C0, DST_NA);
        5'd12: c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NB);
        default: c = mk(CMD_END, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
      endcase
    end
    return c;
  endfunction

  function automatic cmd_t prog_tail(logic [STEP_W-1:0] step);
    cmd_t c;
    case (step)
      5'd0: c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_ZERO, CS_C0,   DST_NA);
      5'd1: c = mk(CMD_MAC,   1'b0, 1'b0, OPD_NA,   CS_LEAK, DST_NA);
      5'd2: c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0,   DST_NA);
      5'd3: c = mk(CMD_LOAD,  1'b0, 1'b0, OPD_ZERO, CS_C0,   DST_NA);
      5'd4: c = mk(CMD_MAC,   1'b0, 1'b0, OPD_NB,   CS_LEAK, DST_NA);
      5'd5: c = mk(CMD_STORE, 1'b0, 1'b0, OPD_ZERO, CS_C0,   DST_NB);
      5'd6: c = mk(CMD_FLUSH, 1'b0, 1'b0, OPD_ZERO, CS_C0,   DST_NA);
      default: c = mk(CMD_COMMIT, 1'b0, 1'b0, OPD_ZERO, CS_C0, DST_NA);
    endcase
    return c;
  endfunction

endpackage

/* design/stereo_biquad_svf_section.sv */
// Top level of the stereo equalizer band: joins the sequencer and the datapath.
// Depends on sbsvf_pkg, sbsvf_controller and sbsvf_datapath.
`timescale 1ns / 1ps

// One second-order equalizer band for a stereo pair, in Direct Form II,
// Transposed Direct Form II or state-variable form, chosen by register 0.
// Both channels share one 32-bit coefficient multiplier, which forms each
// product in steps (two partial products, rounding, accumulate), and the
// sequencer runs one command per cycle otherwise. Each channel whose sample
// is zero also runs the leak and flush commands. The input stalls while a
// pair is in work; a finished result waits in the output register while the
// next pair is processed.
module stereo_biquad_svf_section #(
  parameter int STATE_BITS     = 40,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  sbsvf_pkg::in_beat_t               in_data,
  output logic                              out_valid,
  input  logic                              out_stall,
  output sbsvf_pkg::out_beat_t              out_data,
  input  logic                              cfg_we,
  input  logic [sbsvf_pkg::CFG_IDX_W-1:0]   cfg_index,
  input  logic [sbsvf_pkg::CFG_DATA_W-1:0]  cfg_data
);
  import sbsvf_pkg::*;

  ctrl_t ctrl;
  stat_t stat;

  sbsvf_controller u_ctrl (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .stat     (stat),
    .ctrl     (ctrl)
  );

  sbsvf_datapath #(
    .STATE_BITS     (STATE_BITS),
    .COEF_FRAC_BITS (COEF_FRAC_BITS)
  ) u_dp (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_data   (in_data),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .ctrl      (ctrl),
    .out_stall (out_stall),
    .out_valid (out_valid),
    .out_data  (out_data),
    .stat      (stat)
  );

endmodule

/* design/sbsvf_controller.sv */
// Sequencer for the equalizer band: walks the command program of the
// selected form for each channel and steps the shared multiplier.
// Depends on sbsvf_pkg.
`timescale 1ns / 1ps

module sbsvf_controller (
  input  logic            clk,
  input  logic            rst_n,
  input  logic            in_valid,
  output logic            in_stall,
  input  sbsvf_pkg::stat_t stat,
  output sbsvf_pkg::ctrl_t ctrl
);
  import sbsvf_pkg::*;

  state_t             state_r, state_nxt;
  logic [STEP_W-1:0]  step_r, step_nxt;
  logic               tail_r, tail_nxt;
  logic               ch_r, ch_nxt;
  cmd_t               cmd;

  assign cmd = tail_r ? prog_tail(step_r) : prog_main(stat.form, step_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      step_r  <= '0;
      tail_r  <= 1'b0;
      ch_r    <= 1'b0;
    end else begin
      state_r <= state_nxt;
      step_r  <= step_nxt;
      tail_r  <= tail_nxt;
      ch_r    <= ch_nxt;
    end
  end

  always_comb begin
    state_nxt = state_r;
    step_nxt  = step_r;
    tail_nxt  = tail_r;
    ch_nxt    = ch_r;
    ctrl.op   = DP_IDLE;
    ctrl.ch   = ch_r;
    ctrl.cmd  = cmd;
    in_stall  = (state_r != S_IDLE);
    case (state_r)
      S_IDLE: begin
        if (in_valid) begin
          ctrl.op   = DP_ACCEPT;
          ch_nxt    = 1'b0;
          tail_nxt  = 1'b0;
          step_nxt  = '0;
          state_nxt = S_EXEC;
        end
      end
      S_EXEC: begin
        ctrl.op = DP_EXEC;
        case (cmd.kind)
          CMD_MAC: state_nxt = S_MHI;
          CMD_END: begin
            tail_nxt = 1'b1;
            step_nxt = stat.zero ? '0 : TAIL_COMMIT;
          end
          CMD_COMMIT: begin
            if (ch_r) begin
              state_nxt = S_OUT;
            end else begin
              ch_nxt   = 1'b1;
              tail_nxt = 1'b0;
              step_nxt = '0;
            end
          end
          default: step_nxt = step_r + 1'b1;
        endcase
      end
      S_MHI: begin
        ctrl.op   = DP_MHI;
        state_nxt = S_MSUM;
      end
      S_MSUM: begin
        ctrl.op   = DP_MSUM;
        state_nxt = S_MACC;
      end
      S_MACC: begin
        ctrl.op   = DP_MACC;
        step_nxt  = step_r + 1'b1;
        state_nxt = S_EXEC;
      end
      S_OUT: begin
        if (!stat.out_busy) begin
          ctrl.op   = DP_OUTLOAD;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

/* design/sbsvf_datapath.sv */
// Datapath for the equalizer band: configuration registers, channel state,
// accumulator, node registers, shared two-pass multiplier and result register.
// Depends on sbsvf_pkg.
`timescale 1ns / 1ps

module sbsvf_datapath #(
  parameter int STATE_BITS     = 40,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                                 clk,
  input  logic                                 rst_n,
  input  sbsvf_pkg::in_beat_t                  in_data,
  input  logic                                 cfg_we,
  input  logic [sbsvf_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sbsvf_pkg::CFG_DATA_W-1:0]     cfg_data,
  input  sbsvf_pkg::ctrl_t                     ctrl,
  input  logic                                 out_stall,
  output logic                                 out_valid,
  output sbsvf_pkg::out_beat_t                 out_data,
  output sbsvf_pkg::stat_t                     stat
);
  import sbsvf_pkg::*;

  localparam int SB   = STATE_BITS;
  localparam int HI_W = STATE_BITS - SPLIT;
  localparam int PL_W = COEF_W + SPLIT + 1;
  localparam int PH_W = COEF_W + HI_W;
  localparam int PW   = COEF_W + STATE_BITS + 1;

  localparam logic signed [PW-1:0] RND_C = PW'(64'sd1) <<< (COEF_FRAC_BITS - 1);
  localparam logic signed [PW-1:0] RND_L = PW'(64'sd1) <<< (LEAK_FRAC - 1);
  localparam logic signed [PW-1:0] PLIM  = PW'(64'sd1) <<< 60;
  localparam logic signed [PW-1:0] NLIM  = -PLIM;
  localparam logic signed [ACC_W-1:0] SHI =
    (ACC_W'(64'sd1) <<< (SB - 1)) - ACC_W'(64'sd1);
  localparam logic signed [ACC_W-1:0] SLO = -SHI - ACC_W'(64'sd1);
  localparam logic signed [ACC_W-1:0] OHI =
    (ACC_W'(64'sd1) <<< (SAMPLE_BITS - 1)) - ACC_W'(64'sd1);
  localparam logic signed [ACC_W-1:0] OLO = -OHI - ACC_W'(64'sd1);

  logic        [1:0]             form_r;
  logic signed [COEF_W-1:0]      coef_r [5];
  logic        [LEAK_W-1:0]      leak_r;
  logic        [THR_W-1:0]       thr_r;
  logic signed [SB-1:0]          v1_r [2];
  logic signed [SB-1:0]          v2_r [2];
  logic signed [SB-1:0]          na_r, nb_r, nc_r;
  logic signed [ACC_W-1:0]       acc_r, outv_r;
  logic signed [SAMPLE_BITS-1:0] in_l_r, in_r_r;
  logic signed [SAMPLE_BITS-1:0] res_r [2];
  logic signed [PL_W-1:0]        pl_r;
  logic signed [PH_W-1:0]        ph_r;
  logic signed [TERM_W-1:0]      term_r;
  logic                          flush_r;
  logic                          out_valid_r;
  out_beat_t                     out_data_r;

  logic signed [SAMPLE_BITS-1:0] in_cur;
  logic signed [SB-1:0]          opnd;
  logic signed [COEF_W-1:0]      opa;
  logic signed [SPLIT:0]         bl;
  logic signed [HI_W-1:0]        bh;
  logic                          is_leak;
  logic signed [PW-1:0]          full, shv, clampv;
  logic signed [ACC_W-1:0]       opx;
  logic signed [SB-1:0]          acc_sat;
  logic signed [SAMPLE_BITS-1:0] out_sat;
  logic signed [SB:0]            na_x, mag;
  logic                          below;

  assign in_cur  = ctrl.ch ? in_r_r : in_l_r;
  assign is_leak = (ctrl.cmd.csel == CS_LEAK);

  always_comb begin
    case (ctrl.cmd.opnd)
      OPD_IN:  opnd = SB'(in_cur);
      OPD_V1:  opnd = v1_r[ctrl.ch];
      OPD_V2:  opnd = v2_r[ctrl.ch];
      OPD_NA:  opnd = na_r;
      OPD_NB:  opnd = nb_r;
      OPD_NC:  opnd = nc_r;
      default: opnd = '0;
    endcase
    case (ctrl.cmd.csel)
      CS_C0:   opa = coef_r[0];
      CS_C1:   opa = coef_r[1];
      CS_C2:   opa = coef_r[2];
      CS_C3:   opa = coef_r[3];
      CS_C4:   opa = coef_r[4];
      default: opa = $signed({{(COEF_W - LEAK_W){1'b0}}, leak_r});
    endcase
  end

  assign bl = $signed({1'b0, opnd[SPLIT-1:0]});
  assign bh = $signed(opnd[SB-1:SPLIT]);

  always_comb begin
    full = (PW'(ph_r) <<< SPLIT) + PW'(pl_r) + (is_leak ? RND_L : RND_C);
    shv  = is_leak ? (full >>> LEAK_FRAC) : (full >>> COEF_FRAC_BITS);
    if (shv > PLIM) begin
      clampv = PLIM;
    end else if (shv < NLIM) begin
      clampv = NLIM;
    end else begin
      clampv = shv;
    end
  end

  always_comb begin
    opx = ACC_W'(opnd);
    if (ctrl.cmd.dbl) begin
      opx = opx <<< 1;
    end
    if (ctrl.cmd.neg) begin
      opx = -opx;
    end
    if (acc_r > SHI) begin
      acc_sat = SB'(SHI);
    end else if (acc_r < SLO) begin
      acc_sat = SB'(SLO);
    end else begin
      acc_sat = SB'(acc_r);
    end
    if (outv_r > OHI) begin
      out_sat = SAMPLE_BITS'(OHI);
    end else if (outv_r < OLO) begin
      out_sat = SAMPLE_BITS'(OLO);
    end else begin
      out_sat = SAMPLE_BITS'(outv_r);
    end
    na_x  = (SB + 1)'(na_r);
    mag   = (na_x < 0) ? -na_x : na_x;
    below = ($unsigned(mag) < (SB + 1)'(thr_r));
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      form_r      <= 2'd1;
      coef_r[0]   <= 32'sd268435456;
      coef_r[1]   <= '0;
      coef_r[2]   <= '0;
      coef_r[3]   <= '0;
      coef_r[4]   <= '0;
      leak_r      <= 15'd32440;
      thr_r       <= 16'd16;
      v1_r[0]     <= '0;
      v1_r[1]     <= '0;
      v2_r[0]     <= '0;
      v2_r[1]     <= '0;
      flush_r     <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FORM:  form_r    <= cfg_data[1:0];
          REG_COEF0: coef_r[0] <= $signed(cfg_data);
          REG_COEF1: coef_r[1] <= $signed(cfg_data);
          REG_COEF2: coef_r[2] <= $signed(cfg_data);
          REG_COEF3: coef_r[3] <= $signed(cfg_data);
          REG_COEF4: coef_r[4] <= $signed(cfg_data);
          REG_LEAK:  leak_r    <= cfg_data[LEAK_W-1:0];
          REG_THR:   thr_r     <= cfg_data[THR_W-1:0];
          default:   form_r    <= form_r;
        endcase
      end
      if (ctrl.op == DP_EXEC && ctrl.cmd.kind == CMD_FLUSH) begin
        flush_r <= below;
      end
      if (ctrl.op == DP_EXEC && ctrl.cmd.kind == CMD_COMMIT) begin
        v1_r[ctrl.ch] <= na_r;
        v2_r[ctrl.ch] <= nb_r;
        flush_r       <= 1'b0;
      end
      if (ctrl.op == DP_OUTLOAD) begin
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    case (ctrl.op)
      DP_ACCEPT: begin
        in_l_r <= in_data.left_sample;
        in_r_r <= in_data.right_sample;
      end
      DP_EXEC: begin
        case (ctrl.cmd.kind)
          CMD_LOAD: acc_r <= opx;
          CMD_ADD:  acc_r <= acc_r + opx;
          CMD_MAC:  pl_r  <= PL_W'(opa) * PL_W'(bl);
          CMD_STORE: begin
            case (ctrl.cmd.dst)
              DST_NA:  na_r   <= acc_sat;
              DST_NB:  nb_r   <= acc_sat;
              DST_NC:  nc_r   <= acc_sat;
              default: outv_r <= acc_r;
            endcase
          end
          CMD_FLUSH: begin
            if (below) begin
              na_r <= '0;
              nb_r <= '0;
            end
          end
          CMD_COMMIT: res_r[ctrl.ch] <= flush_r ? '0 : out_sat;
          default: acc_r <= acc_r;
        endcase
      end
      DP_MHI:  ph_r   <= PH_W'(opa) * PH_W'(bh);
      DP_MSUM: term_r <= TERM_W'(clampv);
      DP_MACC: acc_r  <= ctrl.cmd.neg ? acc_r - ACC_W'(term_r) : acc_r + ACC_W'(term_r);
      DP_OUTLOAD: begin
        out_data_r.left_out  <= res_r[0];
        out_data_r.right_out <= res_r[1];
      end
      default: acc_r <= acc_r;
    endcase
  end

  assign out_valid     = out_valid_r;
  assign out_data      = out_data_r;
  assign stat.form     = form_r;
  assign stat.zero     = (in_cur == '0);
  assign stat.out_busy = out_valid_r & out_stall;

endmodule

/* tb/sv/sbsvf_band_checker.sv */
// Checker for the stereo equalizer band: follows the configuration port,
// predicts every output beat in fixed point and compares it field by field.
// Depends on sbsvf_pkg.
`timescale 1ns / 1ps

module sbsvf_band_checker #(
  parameter int STATE_BITS     = 40,
  parameter int COEF_FRAC_BITS = 28
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             in_valid,
  input  logic                             in_stall,
  input  sbsvf_pkg::in_beat_t              in_data,
  input  logic                             out_valid,
  input  logic                             out_stall,
  input  sbsvf_pkg::out_beat_t             out_data,
  input  logic                             cfg_we,
  input  logic [sbsvf_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sbsvf_pkg::CFG_DATA_W-1:0] cfg_data,
  output int                               errors,
  output int                               pending,
  output int                               beats_checked
);
  import sbsvf_pkg::*;

  logic [1:0] form_sel;
  longint     coef[5];
  longint     leak_mul;
  longint     flush_lvl;
  longint     dly1[2];
  longint     dly2[2];
  out_beat_t  band_q[$];
  int         err_cnt;
  int         seen_cnt;

  function automatic longint clip(longint x, int bits);
    longint hi;
    longint lo;
    hi = (64'sd1 <<< (bits - 1)) - 1;
    lo = -hi - 1;
    if (x > hi) return hi;
    if (x < lo) return lo;
    return x;
  endfunction

  function automatic longint scale_round(longint a, longint b, int k);
    logic signed [127:0] pa;
    logic signed [127:0] pb;
    logic signed [127:0] p;
    logic signed [127:0] lim;
    pa = a;
    pb = b;
    lim = 128'sd1 <<< 60;
    p = (pa * pb + (128'sd1 <<< (k - 1))) >>> k;
    if (p > lim) p = lim;
    if (p < -lim) p = -lim;
    return longint'(p);
  endfunction

  function automatic longint cmul(int idx, longint x);
    return scale_round(coef[idx], x, COEF_FRAC_BITS);
  endfunction

  function automatic longint filter_channel(int ch, longint x);
    longint v1, v2, v3, s1, s2, y, n1, n2, mag;
    v1 = dly1[ch];
    v2 = dly2[ch];
    if (form_sel[1]) begin
      v3 = clip(x - v2, STATE_BITS);
      s1 = clip(cmul(0, v1) + cmul(1, v3), STATE_BITS);
      s2 = clip(v2 + cmul(1, v1) + cmul(2, v3), STATE_BITS);
      y  = x + cmul(3, s1);
      n1 = 2 * s1 - v1;
      n2 = 2 * s2 - v2;
    end else if (form_sel[0]) begin
      y  = clip(cmul(0, x) + v1, STATE_BITS);
      n1 = cmul(1, x) - cmul(3, y) + v2;
      n2 = cmul(2, x) - cmul(4, y);
    end else begin
      v3 = clip(x - cmul(3, v1) - cmul(4, v2), STATE_BITS);
      y  = cmul(0, v3) + cmul(1, v1) + cmul(2, v2);
      n1 = v3;
      n2 = v1;
    end
    n1 = clip(n1, STATE_BITS);
    n2 = clip(n2, STATE_BITS);
    if (x == 0) begin
      n1 = clip(scale_round(leak_mul, n1, LEAK_FRAC), STATE_BITS);
      n2 = clip(scale_round(leak_mul, n2, LEAK_FRAC), STATE_BITS);
      mag = (n1 < 0) ? -n1 : n1;
      if (mag < flush_lvl) begin
        n1 = 0;
        n2 = 0;
        y  = 0;
      end
    end
    dly1[ch] = n1;
    dly2[ch] = n2;
    return clip(y, SAMPLE_BITS);
  endfunction

  task automatic report(string what, logic [SAMPLE_BITS-1:0] got,
                        logic [SAMPLE_BITS-1:0] want);
    $display("MISMATCH %s at %0t: got %h, expected %h", what, $time, got, want);
    err_cnt++;
  endtask

  always @(posedge clk) begin
    out_beat_t want;
    longint    l;
    longint    r;
    if (!rst_n) begin
      form_sel  = 2'd1;
      coef[0]   = 268435456;
      coef[1]   = 0;
      coef[2]   = 0;
      coef[3]   = 0;
      coef[4]   = 0;
      leak_mul  = 32440;
      flush_lvl = 16;
      dly1[0] = 0; dly1[1] = 0;
      dly2[0] = 0; dly2[1] = 0;
      band_q.delete();
      err_cnt  = 0;
      seen_cnt = 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          REG_FORM:  form_sel  = cfg_data[1:0];
          REG_COEF0: coef[0]   = longint'($signed(cfg_data));
          REG_COEF1: coef[1]   = longint'($signed(cfg_data));
          REG_COEF2: coef[2]   = longint'($signed(cfg_data));
          REG_COEF3: coef[3]   = longint'($signed(cfg_data));
          REG_COEF4: coef[4]   = longint'($signed(cfg_data));
          REG_LEAK:  leak_mul  = cfg_data[LEAK_W-1:0];
          REG_THR:   flush_lvl = cfg_data[THR_W-1:0];
          default: ;
        endcase
      end
      if (in_valid && !in_stall) begin
        l = in_data.left_sample;
        r = in_data.right_sample;
        want.left_out  = filter_channel(0, l);
        want.right_out = filter_channel(1, r);
        band_q.push_back(want);
      end
      if (out_valid && !out_stall) begin
        seen_cnt++;
        if (band_q.size() == 0) begin
          $display("MISMATCH unexpected output beat at %0t: %h", $time, out_data);
          err_cnt++;
        end else begin
          want = band_q.pop_front();
          if (out_data.left_out !== want.left_out)
            report("left_out", out_data.left_out, want.left_out);
          if (out_data.right_out !== want.right_out)
            report("right_out", out_data.right_out, want.right_out);
        end
      end
    end
    errors        <= err_cnt;
    pending       <= band_q.size();
    beats_checked <= seen_cnt;
  end

endmodule

/* tb/sv/stereo_biquad_svf_section_tb.sv */
// Testbench top for the stereo equalizer band: clock, reset, register setup,
// sample and stall traffic, and the verdict.
// Depends on sbsvf_pkg, stereo_biquad_svf_section and sbsvf_band_checker.
`timescale 1ns / 1ps

module stereo_biquad_svf_section_tb;
  import sbsvf_pkg::*;

  localparam int CYCLE_LIMIT = 2000000;
  localparam int PHASES      = 12;
  localparam int PHASE_BEATS = 128;

  logic                  clk;
  logic                  rst_n;
  logic                  in_valid;
  logic                  in_stall;
  in_beat_t              in_data;
  logic                  out_valid;
  logic                  out_stall;
  out_beat_t             out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;
  int                    errors;
  int                    pending;
  int                    beats_checked;
  int                    cycles = 0;
  int                    sent;
  logic                  sender_calm;
  logic                  long_hold_done;

  stereo_biquad_svf_section DUT (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  sbsvf_band_checker u_checker (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
    .errors(errors), .pending(pending), .beats_checked(beats_checked)
  );

  initial begin
    clk = 1'b0;
    forever #10 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("Timeout after %0d cycles.", cycles);
      $display("RESULT: ERROR");
      $finish;
    end
  end

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(posedge clk);
  endtask

  task automatic settle();
    do @(posedge clk); while (pending != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic send_pair(logic signed [SAMPLE_BITS-1:0] l,
                           logic signed [SAMPLE_BITS-1:0] r);
    int gap;
    gap = sender_calm ? 0 : $urandom_range(0, 11);
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_data.left_sample  <= l;
    in_data.right_sample <= r;
    do @(posedge clk); while (in_stall);
    sent++;
  endtask

  task automatic end_burst();
    in_valid <= 1'b0;
    settle();
  endtask

  function automatic logic [CFG_DATA_W-1:0] draw_coef(int mode);
    case (mode)
      0: return $urandom;
      1: return $urandom_range(0, 1) ? 32'h7FFF_FFFF : 32'h8000_0000;
      2: return 32'h1000_0000 + $urandom_range(0, 32'h0080_0000) - 32'h0040_0000;
      default: return $urandom_range(0, 32'h0800_0000) - 32'h0400_0000;
    endcase
  endfunction

  function automatic logic signed [SAMPLE_BITS-1:0] draw_sample();
    case ($urandom_range(0, 9))
      0: return 24'sh7FFFFF;
      1: return 24'sh800000;
      2, 3: return SAMPLE_BITS'($urandom_range(0, 511) - 256);
      default: return SAMPLE_BITS'($urandom);
    endcase
  endfunction

  task automatic load_random_setup(int ph);
    int cm;
    cm = (ph == 3) ? 1 : (ph % 3 == 0) ? 0 : $urandom_range(2, 3);
    write_reg(REG_FORM, ph % 4);
    write_reg(REG_COEF0, (cm >= 2) ? 32'h1000_0000 : draw_coef(cm));
    write_reg(REG_COEF1, draw_coef(cm));
    write_reg(REG_COEF2, draw_coef(cm));
    write_reg(REG_COEF3, draw_coef(cm == 2 ? 3 : cm));
    write_reg(REG_COEF4, draw_coef(cm == 2 ? 3 : cm));
    case (ph % 4)
      0: write_reg(REG_LEAK, 32767);
      1: write_reg(REG_LEAK, 0);
      2: write_reg(REG_LEAK, $urandom_range(4096, 20000));
      default: write_reg(REG_LEAK, $urandom_range(0, 32767));
    endcase
    case (ph % 3)
      0: write_reg(REG_THR, 65535);
      1: write_reg(REG_THR, 0);
      default: write_reg(REG_THR, $urandom_range(0, 65535));
    endcase
    cfg_we <= 1'b0;
  endtask

  // Receiver: random stalls per beat, calm stretches, and one long hold.
  initial begin
    int gap;
    out_stall = 1'b0;
    long_hold_done = 1'b0;
    wait (rst_n === 1'b1);
    forever begin
      if (!long_hold_done && beats_checked >= 400) begin
        long_hold_done = 1'b1;
        out_stall <= 1'b1;
        repeat (700) @(posedge clk);
      end else begin
        gap = ((beats_checked / 100) % 3 == 1) ? 0 : $urandom_range(0, 11);
        if (gap > 0) begin
          out_stall <= 1'b1;
          repeat (gap) @(posedge clk);
        end
      end
      out_stall <= 1'b0;
      do @(posedge clk); while (!out_valid);
    end
  end

  initial begin
    int n;
    int zl;
    int zr;
    sent        = 0;
    sender_calm = 1'b0;
    rst_n       = 1'b0;
    in_valid    = 1'b0;
    in_data     = '0;
    cfg_we      = 1'b0;
    cfg_index   = '0;
    cfg_data    = '0;
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // Reset setup passes samples through unchanged; check the extremes.
    send_pair(24'sh7FFFFF, 24'sh800000);
    send_pair(24'shAAAAAA, 24'sh555555);
    send_pair(24'sh000001, -24'sh000001);
    send_pair(24'sh000000, 24'sh123456);
    end_burst();

    // Each form code, including code three, followed by a decay; code three runs with flushing off.
    for (int f = 0; f < 4; f++) begin
      write_reg(REG_FORM, f);
      write_reg(REG_COEF0, 32'h0800_0000);
      write_reg(REG_COEF1, 32'h0400_0000);
      write_reg(REG_COEF2, 32'hFC00_0000);
      write_reg(REG_COEF3, 32'hF800_0000);
      write_reg(REG_COEF4, 32'h0200_0000);
      write_reg(REG_LEAK, 16384);
      write_reg(REG_THR, (f == 3) ? 0 : 65535);
      cfg_we <= 1'b0;
      send_pair(24'sh7FFFFF, 24'sh800000);
      send_pair(24'sh400000, 24'sh000000);
      send_pair(24'sh000000, 24'sh000000);
      send_pair(24'sh000000, 24'sh000000);
      end_burst();
    end

    for (int ph = 0; ph < PHASES; ph++) begin
      load_random_setup(ph);
      sender_calm = (ph % 4 == 2);
      n = 0;
      while (n < PHASE_BEATS) begin
        if ($urandom_range(0, 3) != 0) begin
          // Signal burst then silence on the left (and usually the right), so states decay toward the flush point.
          repeat ($urandom_range(1, 8)) begin
            send_pair(draw_sample(), draw_sample());
            n++;
          end
          zl = $urandom_range(1, 20);
          zr = $urandom_range(0, 3) == 0 ? 0 : zl;
          for (int z = 0; z < zl; z++) begin
            send_pair(24'sh0, (z < zr) ? 24'sh0 : draw_sample());
            n++;
          end
        end else begin
          send_pair(draw_sample(), $urandom_range(0, 1) ? 24'sh0 : draw_sample());
          n++;
        end
      end
      end_burst();
    end

    repeat (150) @(posedge clk);
    $display("Ran %0d sample pairs over %0d register setups, all four form codes,",
             sent, PHASES + 5);
    $display("with silence decay, flushing, saturation and heavy output back-pressure.");
    if (errors == 0 && pending == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
